>>> rtl/upi_pkg.sv
package upi_pkg;

	// table size default and fixed field widths
	localparam int SINE_TABLE_BITS_DEF = 10;
	localparam int PROD_W              = 57;
	localparam int OUT_W               = 200;
	localparam int IN_W                = 64;
	localparam int APB_ADDR_W          = 3;
	localparam int APB_DATA_W          = 32;
	localparam logic [23:0] DEFAULT_STEP_RST = 24'd52429;

	// register word index on the config port
	localparam logic REG_DEFAULT_STEP = 1'b0;

	// item kinds carried in tuser
	localparam logic FUNC_VEL  = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	localparam real UPI_HALF_PI = 1.5707963267948966;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MC,
		S_MCD,
		S_MS,
		S_MSD,
		S_ROT,
		S_YAW,
		S_QUAT
	} upi_state_t;

	typedef enum logic [1:0] {
		A_SPEED,
		A_PROD,
		A_RATE
	} upi_a_sel_t;

	typedef enum logic [1:0] {
		B_COS,
		B_SIN,
		B_DT
	} upi_b_sel_t;

	typedef struct packed {
		logic       load_vel;
		logic       load_tick;
		logic       mul_en;
		upi_a_sel_t a_sel;
		upi_b_sel_t b_sel;
		logic       add_x;
		logic       add_y;
		logic       add_yaw;
		logic       load_out;
	} upi_cmd_t;

	// quarter-wave sine entry m, Q0.15, rounded half up
	function automatic logic [14:0] upi_qsine(int m, int bits);
		real ang;
		real v;
		ang = UPI_HALF_PI * real'(m);
		// scale down by the quarter-wave entry count, 2^(bits-2)
		for (int k = 2; k < bits; k++) begin
			ang = ang * 0.5;
		end
		v = $floor(32767.0 * $sin(ang) + 0.5);
		if (v > 32767.0) begin
			v = 32767.0;
		end
		return 15'($rtoi(v));
	endfunction

endpackage

>>> rtl/unicycle_pose_integrator.sv
// channel   | dir | signals                              | content
// s_axis    | in  | tvalid tready tdata[63:0] tuser[0:0] | velocity command or time tick
// m_axis    | out | tvalid tready tdata[199:0]           | pose, quaternion, speeds
// apb       | in  | psel penable pwrite paddr pwdata ... | default_step at byte 0
//
// a velocity beat is taken and gives no result
// a tick beat runs: accept, six steps through one shared 32x25
// multiplier and the accumulators, then the result register load
// the last step waits while the result register still holds an untaken beat
// s_axis_tready is high only between items; a waiting result does not block input
// arst_n clears pose, speeds and default_step (52429); no clearing pass
module unicycle_pose_integrator
	import upi_pkg::*;
#(
	parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// lin_speed[15:0], turn_rate[39:16], elapsed[63:40]
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_W-1:0]       s_axis_tdata,
	// func[0]
	input  logic [0:0]            s_axis_tuser,
	// x_pos[47:0], y_pos[95:48], heading[127:96], quat_z[143:128],
	// quat_w[159:144], lin_speed_out[175:160], turn_rate_out[199:176]
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_W-1:0]      m_axis_tdata,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	upi_cmd_t    cmd;
	logic        cfg_we;
	logic        reg_hit;
	logic [23:0] default_step;

	// config register decode
	assign pready  = 1'b1;
	assign reg_hit = (paddr[2] == REG_DEFAULT_STEP);
	assign cfg_we  = psel && penable && pwrite && pready && reg_hit;
	assign prdata  = reg_hit ? {8'b0, default_step} : '0;

	upi_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_func  (s_axis_tuser[0]),
		.s_ready (s_axis_tready),
		.m_valid (m_axis_tvalid),
		.m_ready (m_axis_tready),
		.cmd     (cmd)
	);

	upi_datapath #(
		.SINE_TABLE_BITS (SINE_TABLE_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.in_data      (s_axis_tdata),
		.cfg_we       (cfg_we),
		.cfg_wdata    (pwdata[23:0]),
		.default_step (default_step),
		.out_data     (m_axis_tdata)
	);

endmodule

>>> rtl/upi_ctrl.sv
module upi_ctrl
	import upi_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_valid,
	input  logic     s_func,
	output logic     s_ready,
	output logic     m_valid,
	input  logic     m_ready,
	output upi_cmd_t cmd
);

	upi_state_t state_q;
	upi_state_t state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || m_ready;
	assign s_ready  = (state_q == S_IDLE);
	assign m_valid  = out_valid_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// next state and datapath commands
	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.a_sel     = A_SPEED;
		cmd.b_sel     = B_DT;
		case (state_q)
			S_IDLE: begin
				if (s_valid) begin
					if (s_func == FUNC_TICK) begin
						cmd.load_tick = 1'b1;
						state_d       = S_MC;
					end else begin
						cmd.load_vel = 1'b1;
					end
				end
			end
			S_MC: begin
				cmd.mul_en = 1'b1;
				cmd.a_sel  = A_SPEED;
				cmd.b_sel  = B_COS;
				state_d    = S_MCD;
			end
			S_MCD: begin
				cmd.mul_en = 1'b1;
				cmd.a_sel  = A_PROD;
				cmd.b_sel  = B_DT;
				state_d    = S_MS;
			end
			S_MS: begin
				cmd.mul_en = 1'b1;
				cmd.a_sel  = A_SPEED;
				cmd.b_sel  = B_SIN;
				cmd.add_x  = 1'b1;
				state_d    = S_MSD;
			end
			S_MSD: begin
				cmd.mul_en = 1'b1;
				cmd.a_sel  = A_PROD;
				cmd.b_sel  = B_DT;
				state_d    = S_ROT;
			end
			S_ROT: begin
				cmd.mul_en = 1'b1;
				cmd.a_sel  = A_RATE;
				cmd.b_sel  = B_DT;
				cmd.add_y  = 1'b1;
				state_d    = S_YAW;
			end
			S_YAW: begin
				cmd.add_yaw = 1'b1;
				state_d     = S_QUAT;
			end
			S_QUAT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// result register is never overwritten while a beat waits
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || m_ready))
		else $error("result loaded over a waiting beat");

	// a tick starts the multiply sequence
	a_tick_start: assert property (@(posedge clk) disable iff (!arst_n)
		(s_valid && s_ready && s_func == FUNC_TICK) |=> state_q == S_MC)
		else $error("tick did not start the sequence");

	// a velocity item leaves the block idle and gives no result
	a_vel_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(s_valid && s_ready && s_func == FUNC_VEL) |=> (state_q == S_IDLE && !cmd.load_out))
		else $error("velocity item disturbed the sequence");

	// a result only appears after the final step
	a_out_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_QUAT)
		else $error("result appeared outside the final step");

	// at most one accumulator updates per cycle
	a_one_add: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.add_x, cmd.add_y, cmd.add_yaw}))
		else $error("two accumulators updated together");

endmodule

>>> rtl/upi_datapath.sv
module upi_datapath
	import upi_pkg::*;
#(
	parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  upi_cmd_t          cmd,
	input  logic [IN_W-1:0]   in_data,
	input  logic              cfg_we,
	input  logic [23:0]       cfg_wdata,
	output logic [23:0]       default_step,
	output logic [OUT_W-1:0]  out_data
);

	localparam int B     = SINE_TABLE_BITS;
	localparam int TBL_Q = 1 << (B - 2);

	// quarter-wave sine table
	logic [14:0] qtab [0:TBL_Q];

	for (genvar m = 0; m <= TBL_Q; m++) begin : g_tab
		localparam logic [14:0] VAL = upi_qsine(m, B);
		assign qtab[m] = VAL;
	end

	// full-wave lookup from the quarter table
	function automatic logic signed [15:0] sine_at(input logic [B-1:0] i);
		logic [1:0]   q;
		logic [B-2:0] r;
		logic [B-2:0] ri;
		logic signed [15:0] v;
		q  = i[B-1:B-2];
		r  = {1'b0, i[B-3:0]};
		ri = (B-1)'(TBL_Q) - r;
		case (q)
			2'd0:    v = $signed({1'b0, qtab[r]});
			2'd1:    v = $signed({1'b0, qtab[ri]});
			2'd2:    v = -$signed({1'b0, qtab[r]});
			default: v = -$signed({1'b0, qtab[ri]});
		endcase
		return v;
	endfunction

	logic [47:0]        x_q;
	logic [47:0]        y_q;
	logic [31:0]        yaw_q;
	logic signed [15:0] speed_q;
	logic signed [23:0] rate_q;
	logic [23:0]        step_q;
	logic [23:0]        dt_q;
	logic signed [15:0] sin_q;
	logic signed [15:0] cos_q;
	logic signed [PROD_W-1:0] prod_q;

	logic [31:0]        half;
	logic [31:0]        ang;
	logic [B-1:0]       idx;
	logic signed [15:0] s_val;
	logic signed [15:0] c_val;
	logic signed [31:0] mul_a;
	logic signed [24:0] mul_b;
	logic signed [PROD_W-1:0] prod_d;
	logic signed [PROD_W-1:0] pos_step;
	logic signed [PROD_W-1:0] yaw_step;
	logic [23:0]        elapsed;

	assign default_step = step_q;
	assign elapsed      = in_data[63:40];

	// angle for the lookup: old heading at tick start, half angle at the end
	assign half  = {yaw_q[31], yaw_q[31:1]};
	assign ang   = cmd.load_out ? half : yaw_q;
	assign idx   = ang[31 -: B];
	assign s_val = sine_at(idx);
	assign c_val = sine_at(idx + B'(TBL_Q));

	// shared multiplier operands
	always_comb begin
		case (cmd.a_sel)
			A_SPEED: mul_a = 32'(speed_q);
			A_PROD:  mul_a = $signed(prod_q[31:0]);
			A_RATE:  mul_a = 32'(rate_q);
			default: mul_a = '0;
		endcase
		case (cmd.b_sel)
			B_COS:   mul_b = 25'(cos_q);
			B_SIN:   mul_b = 25'(sin_q);
			B_DT:    mul_b = $signed({1'b0, dt_q});
			default: mul_b = '0;
		endcase
	end

	assign prod_d   = PROD_W'(mul_a) * PROD_W'(mul_b);
	assign pos_step = prod_q >>> 15;
	assign yaw_step = prod_q >>> 4;

	// pose, speeds and config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q     <= '0;
			y_q     <= '0;
			yaw_q   <= '0;
			speed_q <= '0;
			rate_q  <= '0;
			step_q  <= DEFAULT_STEP_RST;
		end else begin
			if (cfg_we) begin
				step_q <= cfg_wdata;
			end
			if (cmd.load_vel) begin
				speed_q <= $signed(in_data[15:0]);
				rate_q  <= $signed(in_data[39:16]);
			end
			if (cmd.add_x) begin
				x_q <= x_q + pos_step[47:0];
			end
			if (cmd.add_y) begin
				y_q <= y_q + pos_step[47:0];
			end
			if (cmd.add_yaw) begin
				yaw_q <= yaw_q + yaw_step[31:0];
			end
		end
	end

	// per-tick working registers and result register
	always_ff @(posedge clk) begin
		if (cmd.load_tick) begin
			dt_q  <= (elapsed == '0) ? step_q : elapsed;
			sin_q <= s_val;
			cos_q <= c_val;
		end
		if (cmd.mul_en) begin
			prod_q <= prod_d;
		end
		if (cmd.load_out) begin
			out_data <= {rate_q, speed_q, c_val, s_val, yaw_q, y_q, x_q};
		end
	end

endmodule
